// ===== rtl/csm_pkg.sv =====
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types and codes for the calendar schedule match table: request and
// response payloads, the stored slot entry, command, class and status codes.
// ----------------------------------------------------------------------------
package csm_pkg;

    // Command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_SAVE   = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_LOOKUP = 3'd4;

    // Schedule classes
    localparam logic [2:0] CLASS_HOURLY  = 3'd0;
    localparam logic [2:0] CLASS_DAILY   = 3'd1;
    localparam logic [2:0] CLASS_WEEKLY  = 3'd2;
    localparam logic [2:0] CLASS_MONTHLY = 3'd3;
    localparam logic [2:0] CLASS_YEARLY  = 3'd4;

    // Response status codes
    localparam logic [2:0] ST_FIRED      = 3'd0;
    localparam logic [2:0] ST_NO_MATCH   = 3'd1;
    localparam logic [2:0] ST_SAVED      = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_DELETED    = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd5;
    localparam logic [2:0] ST_CLEARED    = 3'd6;
    localparam logic [2:0] ST_LOOKUP_HIT = 3'd7;

    // A tick reports at most this many slots.
    localparam logic [3:0] RESULT_CAP = 4'd8;

    typedef struct packed {
        logic [2:0] command;
        logic [2:0] sched_class;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [2:0] weekday;
        logic [4:0] hour_value;
        logic [5:0] minute_value;
        logic [7:0] retain_count;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] slot_index;
        logic [7:0] retain_out;
        logic       last_result;
    } rsp_t;

    typedef struct packed {
        logic [2:0] sched_class;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [2:0] weekday;
        logic [4:0] hour_value;
        logic [5:0] minute_value;
        logic [7:0] retain_count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Per-slot compare results from the slot evaluator.
    typedef struct packed {
        logic live;
        logic equal;
        logic time_hit;
    } match_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_FINISH
    } state_t;

endpackage

// ===== rtl/csm_ram.sv =====
// ----------------------------------------------------------------------------
// csm_ram
// Generic single-write, single-read RAM with a registered read port. The read
// register holds its value when no read is issued.
// ----------------------------------------------------------------------------
module csm_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/csm_slot_eval.sv =====
// ----------------------------------------------------------------------------
// csm_slot_eval
// Compares one stored slot against the held request: liveness, equality of
// the schedule fields, and the class-specific time match used by a tick.
// ----------------------------------------------------------------------------
module csm_slot_eval (
    input  csm_pkg::entry_t entry,
    input  csm_pkg::req_t   req,
    output csm_pkg::match_t result
);
    import csm_pkg::*;

    logic hour_eq;
    logic time_hit;

    assign hour_eq = (entry.hour_value == req.hour_value);

    // Each class stands on its own; unknown classes never fire.
    always_comb
    begin
        case (entry.sched_class)
            CLASS_HOURLY:  time_hit = 1'b1;
            CLASS_DAILY:   time_hit = hour_eq;
            CLASS_WEEKLY:  time_hit = hour_eq && (entry.weekday == req.weekday);
            CLASS_MONTHLY: time_hit = hour_eq && (entry.day_of_month == req.day_of_month);
            CLASS_YEARLY:  time_hit = hour_eq && (entry.day_of_month == req.day_of_month)
                                      && (entry.month == req.month);
            default:       time_hit = 1'b0;
        endcase
    end

    assign result.live     = (entry.retain_count != 8'd0);
    assign result.equal    = (entry.sched_class == req.sched_class)
                          && (entry.month == req.month)
                          && (entry.day_of_month == req.day_of_month)
                          && (entry.weekday == req.weekday)
                          && hour_eq
                          && (entry.minute_value == req.minute_value);
    assign result.time_hit = (entry.minute_value == req.minute_value) && time_hit;

endmodule

// ===== rtl/calendar_schedule_match_table.sv =====
// ----------------------------------------------------------------------------
// calendar_schedule_match_table
// Scan: a tick, save, delete or lookup scans one slot per cycle, pausing while
//   a held tick hit waits for the response register; clear needs no scan.
// Throughput: one request at a time; a new request is accepted only once the
//   previous one is done, so response stalls also hold off the next request.
// Reset: every slot reads as all zero (per-slot valid bits cleared at once).
// ----------------------------------------------------------------------------
module calendar_schedule_match_table #(
    parameter int NUM_SLOTS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  csm_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output csm_pkg::rsp_t rsp_data
);
    import csm_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(NUM_SLOTS);

    // The slot table lives in a RAM. A slot whose valid bit is clear reads
    // as all zero, which gives reset and clear without a sweep.
    state_t               state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                 eval_valid_reg, eval_valid_next;
    logic [SLOT_W-1:0]    eval_idx_reg, eval_idx_next;
    logic [3:0]           match_cnt_reg, match_cnt_next;
    logic [2:0]           pend_idx_reg, pend_idx_next;
    logic [7:0]           pend_ret_reg, pend_ret_next;
    logic                 hit_found_reg, hit_found_next;
    logic [SLOT_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [7:0]           hit_ret_reg, hit_ret_next;
    logic                 free_found_reg, free_found_next;
    logic [SLOT_W-1:0]    free_idx_reg, free_idx_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    entry_t               ram_wdata;
    logic                 ram_re;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    entry_t               eval_entry;
    match_t               slot_match;
    logic                 push_ok;
    logic                 push;
    rsp_t                 push_data;
    logic                 tick_take;
    logic                 stall;
    logic [SLOT_W+2:0]    eval_idx_ext;
    logic [SLOT_W+2:0]    hit_idx_ext;
    logic [SLOT_W+2:0]    free_idx_ext;
    entry_t               req_entry;

    csm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Slot data arrives from the RAM read register in the cycle after its read; the valid bits stay fixed
    // during a scan, so sampling them at evaluation time is consistent.
    assign eval_entry = valid_reg[eval_idx_reg] ? entry_t'(ram_rdata) : '0;

    csm_slot_eval u_slot_eval (
        .entry  (eval_entry),
        .req    (req_reg),
        .result (slot_match)
    );

    // Slot numbers are reported by their low three bits.
    assign eval_idx_ext = {3'b000, eval_idx_reg};
    assign hit_idx_ext  = {3'b000, hit_idx_reg};
    assign free_idx_ext = {3'b000, free_idx_reg};

    assign req_entry.sched_class  = req_reg.sched_class;
    assign req_entry.month        = req_reg.month;
    assign req_entry.day_of_month = req_reg.day_of_month;
    assign req_entry.weekday      = req_reg.weekday;
    assign req_entry.hour_value   = req_reg.hour_value;
    assign req_entry.minute_value = req_reg.minute_value;
    assign req_entry.retain_count = req_reg.retain_count;

    // The response register accepts a new response when empty or draining.
    assign push_ok = !rsp_valid_reg || rsp_ready;

    // A tick holds its newest hit back until it knows whether another one
    // follows, so the final response can carry the last flag. Pushing the
    // held hit needs the response register; the scan pauses until it frees.
    assign tick_take = eval_valid_reg && (req_reg.command == CMD_TICK)
                    && slot_match.live && slot_match.time_hit
                    && (match_cnt_reg < RESULT_CAP);
    assign stall     = tick_take && (match_cnt_reg != 4'd0) && !push_ok;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_data.command)
                        CMD_TICK,
                        CMD_SAVE,
                        CMD_DELETE,
                        CMD_LOOKUP: state_next = FSM_SCAN;
                        CMD_CLEAR:  state_next = FSM_FINISH;
                        default:    state_next = FSM_IDLE;
                    endcase
                end
            end
            FSM_SCAN:
            begin
                if ((rd_cnt_reg == SLOT_END) && !eval_valid_reg)
                begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_FINISH:
            begin
                if (push_ok)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        req_next        = req_reg;
        rd_cnt_next     = rd_cnt_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        match_cnt_next  = match_cnt_reg;
        pend_idx_next   = pend_idx_reg;
        pend_ret_next   = pend_ret_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_ret_next    = hit_ret_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        push            = 1'b0;
        push_data       = '0;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata       = req_entry;
        ram_re          = 1'b0;
        ram_raddr       = rd_cnt_reg[SLOT_W-1:0];

        case (state_reg)
            FSM_IDLE:
            begin
                if (req_valid)
                begin
                    req_next        = req_data;
                    rd_cnt_next     = '0;
                    eval_valid_next = 1'b0;
                    match_cnt_next  = 4'd0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                end
            end

            FSM_SCAN:
            begin
                if (!stall)
                begin
                    // Issue the next read while the previous slot is judged.
                    if (rd_cnt_reg != SLOT_END)
                    begin
                        ram_re          = 1'b1;
                        rd_cnt_next     = rd_cnt_reg + 1'b1;
                        eval_valid_next = 1'b1;
                        eval_idx_next   = rd_cnt_reg[SLOT_W-1:0];
                    end
                    else
                    begin
                        eval_valid_next = 1'b0;
                    end

                    if (eval_valid_reg)
                    begin
                        case (req_reg.command)
                            CMD_TICK:
                            begin
                                if (tick_take)
                                begin
                                    if (match_cnt_reg != 4'd0)
                                    begin
                                        push                  = 1'b1;
                                        push_data.status      = ST_FIRED;
                                        push_data.slot_index  = pend_idx_reg;
                                        push_data.retain_out  = pend_ret_reg;
                                        push_data.last_result = 1'b0;
                                    end
                                    pend_idx_next  = eval_idx_ext[2:0];
                                    pend_ret_next  = eval_entry.retain_count;
                                    match_cnt_next = match_cnt_reg + 4'd1;
                                end
                            end
                            CMD_SAVE:
                            begin
                                if (slot_match.live && slot_match.equal && !hit_found_reg)
                                begin
                                    hit_found_next = 1'b1;
                                    hit_idx_next   = eval_idx_reg;
                                end
                                if (!slot_match.live && !free_found_reg)
                                begin
                                    free_found_next = 1'b1;
                                    free_idx_next   = eval_idx_reg;
                                end
                            end
                            CMD_DELETE,
                            CMD_LOOKUP:
                            begin
                                // Liveness is not checked: a free slot with
                                // equal fields is found too.
                                if (slot_match.equal && !hit_found_reg)
                                begin
                                    hit_found_next = 1'b1;
                                    hit_idx_next   = eval_idx_reg;
                                    hit_ret_next   = eval_entry.retain_count;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end

            FSM_FINISH:
            begin
                if (push_ok)
                begin
                    push                  = 1'b1;
                    push_data.last_result = 1'b1;
                    case (req_reg.command)
                        CMD_TICK:
                        begin
                            if (match_cnt_reg != 4'd0)
                            begin
                                push_data.status     = ST_FIRED;
                                push_data.slot_index = pend_idx_reg;
                                push_data.retain_out = pend_ret_reg;
                            end
                            else
                            begin
                                push_data.status = ST_NO_MATCH;
                            end
                        end
                        CMD_SAVE:
                        begin
                            // An equal live slot gets the new retain; its
                            // fields already equal the request's.
                            if (hit_found_reg)
                            begin
                                ram_we                  = 1'b1;
                                ram_waddr               = hit_idx_reg;
                                valid_next[hit_idx_reg] = 1'b1;
                                push_data.status        = ST_SAVED;
                                push_data.slot_index    = hit_idx_ext[2:0];
                            end
                            else if (free_found_reg)
                            begin
                                ram_we                   = 1'b1;
                                ram_waddr                = free_idx_reg;
                                valid_next[free_idx_reg] = 1'b1;
                                push_data.status         = ST_SAVED;
                                push_data.slot_index     = free_idx_ext[2:0];
                            end
                            else
                            begin
                                push_data.status = ST_FULL;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (hit_found_reg)
                            begin
                                valid_next[hit_idx_reg] = 1'b0;
                                push_data.status        = ST_DELETED;
                                push_data.slot_index    = hit_idx_ext[2:0];
                            end
                            else
                            begin
                                push_data.status = ST_NOT_FOUND;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            if (hit_found_reg)
                            begin
                                push_data.status     = ST_LOOKUP_HIT;
                                push_data.slot_index = hit_idx_ext[2:0];
                                push_data.retain_out = hit_ret_reg;
                            end
                            else
                            begin
                                push_data.status = ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            // Clear is the only other command that gets here.
                            valid_next       = '0;
                            push_data.status = ST_CLEARED;
                        end
                    endcase
                end
            end

            default:
            begin
            end
        endcase

        if (push)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = push_data;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && !rsp_ready;
            rsp_next       = rsp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_IDLE;
            rd_cnt_reg     <= '0;
            eval_valid_reg <= 1'b0;
            match_cnt_reg  <= 4'd0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            eval_valid_reg <= eval_valid_next;
            match_cnt_reg  <= match_cnt_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        eval_idx_reg <= eval_idx_next;
        pend_idx_reg <= pend_idx_next;
        pend_ret_reg <= pend_ret_next;
        hit_idx_reg  <= hit_idx_next;
        hit_ret_reg  <= hit_ret_next;
        free_idx_reg <= free_idx_next;
        rsp_reg      <= rsp_next;
    end

    assign req_ready = (state_reg == FSM_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule
